// ----- design/rtxq_pkg.sv -----
// Package for the xterm-256 quantizer: the pipeline item type, palette constants
// and small helper functions for level snapping and distances.
// No dependencies.
package rtxq_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned CubeDW  = 6;
  localparam int unsigned ErrW    = 18;
  localparam int unsigned IndexW  = 8;

  localparam int unsigned GreyCount  = 24;
  localparam int unsigned GreyFirst  = 232;
  localparam int unsigned GreyOffset = 8;
  localparam int unsigned GreyStep   = 10;

  localparam int unsigned CubeBase        = 16;
  localparam int unsigned CubeRedStride   = 36;
  localparam int unsigned CubeGreenStride = 6;

  // Snap thresholds: a channel above the threshold moves to the next level up.
  // Midpoints that fall on an integer go to the lower level.
  localparam logic [ChanW-1:0] Thresh0 = 8'd47;
  localparam logic [ChanW-1:0] Thresh1 = 8'd115;
  localparam logic [ChanW-1:0] Thresh2 = 8'd155;
  localparam logic [ChanW-1:0] Thresh3 = 8'd195;
  localparam logic [ChanW-1:0] Thresh4 = 8'd235;

  typedef struct packed {
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic [IndexW-1:0] best_index;
    logic [ErrW-1:0]   best_err;
  } item_t;

  function automatic logic [ChanW-1:0] cube_level(input logic [LevelW-1:0] idx);
    logic [ChanW-1:0] lvl;
    case (idx)
      3'd0:    lvl = 8'd0;
      3'd1:    lvl = 8'd95;
      3'd2:    lvl = 8'd135;
      3'd3:    lvl = 8'd175;
      3'd4:    lvl = 8'd215;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

  function automatic logic [LevelW-1:0] snap_index(input logic [ChanW-1:0] v);
    logic [LevelW-1:0] idx;
    if (v > Thresh4) begin
      idx = 3'd5;
    end else if (v > Thresh3) begin
      idx = 3'd4;
    end else if (v > Thresh2) begin
      idx = 3'd3;
    end else if (v > Thresh1) begin
      idx = 3'd2;
    end else if (v > Thresh0) begin
      idx = 3'd1;
    end else begin
      idx = 3'd0;
    end
    return idx;
  endfunction

  function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    logic [ChanW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d;
  endfunction

endpackage

// ----- design/rtxq_cube_cell.sv -----
// Head cell of the quantizer chain: snaps each channel to the nearest cube level
// and forms the cube palette index and its squared distance over two stages.
// Depends on rtxq_pkg.
module rtxq_cube_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [rtxq_pkg::ChanW-1:0]      red_i,
  input  logic [rtxq_pkg::ChanW-1:0]      green_i,
  input  logic [rtxq_pkg::ChanW-1:0]      blue_i,
  output logic                            valid_o,
  output rtxq_pkg::item_t                 item_o
);

  // First stage: level indexes and per-channel distances to the snapped level.
  logic                            valid_a_q;
  logic [rtxq_pkg::ChanW-1:0]      red_a_q, green_a_q, blue_a_q;
  logic [rtxq_pkg::LevelW-1:0]     ri_a_q, gi_a_q, bi_a_q;
  logic [rtxq_pkg::CubeDW-1:0]     rd_a_q, gd_a_q, bd_a_q;

  logic [rtxq_pkg::LevelW-1:0]     ri_d, gi_d, bi_d;
  logic [rtxq_pkg::CubeDW-1:0]     rd_d, gd_d, bd_d;

  always_comb begin
    ri_d = rtxq_pkg::snap_index(red_i);
    gi_d = rtxq_pkg::snap_index(green_i);
    bi_d = rtxq_pkg::snap_index(blue_i);
    // The distance to the nearest level never exceeds 47, so six bits hold it.
    rd_d = rtxq_pkg::CubeDW'(rtxq_pkg::abs_diff(red_i,   rtxq_pkg::cube_level(ri_d)));
    gd_d = rtxq_pkg::CubeDW'(rtxq_pkg::abs_diff(green_i, rtxq_pkg::cube_level(gi_d)));
    bd_d = rtxq_pkg::CubeDW'(rtxq_pkg::abs_diff(blue_i,  rtxq_pkg::cube_level(bi_d)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    red_a_q   <= red_i;
    green_a_q <= green_i;
    blue_a_q  <= blue_i;
    ri_a_q    <= ri_d;
    gi_a_q    <= gi_d;
    bi_a_q    <= bi_d;
    rd_a_q    <= rd_d;
    gd_a_q    <= gd_d;
    bd_a_q    <= bd_d;
  end

  // Second stage: squares, their sum and the cube index.
  logic                 valid_q;
  rtxq_pkg::item_t      item_q;
  rtxq_pkg::item_t      item_d;
  logic [2*rtxq_pkg::CubeDW-1:0] rsq, gsq, bsq;

  always_comb begin
    rsq = (2*rtxq_pkg::CubeDW)'(rd_a_q) * (2*rtxq_pkg::CubeDW)'(rd_a_q);
    gsq = (2*rtxq_pkg::CubeDW)'(gd_a_q) * (2*rtxq_pkg::CubeDW)'(gd_a_q);
    bsq = (2*rtxq_pkg::CubeDW)'(bd_a_q) * (2*rtxq_pkg::CubeDW)'(bd_a_q);
    item_d.red        = red_a_q;
    item_d.green      = green_a_q;
    item_d.blue       = blue_a_q;
    item_d.best_err   = rtxq_pkg::ErrW'(rsq) + rtxq_pkg::ErrW'(gsq)
                      + rtxq_pkg::ErrW'(bsq);
    item_d.best_index = rtxq_pkg::IndexW'(rtxq_pkg::CubeBase)
                      + rtxq_pkg::IndexW'(rtxq_pkg::CubeRedStride) * rtxq_pkg::IndexW'(ri_a_q)
                      + rtxq_pkg::IndexW'(rtxq_pkg::CubeGreenStride) * rtxq_pkg::IndexW'(gi_a_q)
                      + rtxq_pkg::IndexW'(bi_a_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- design/rtxq_grey_cell.sv -----
// One grey cell of the quantizer chain: checks one grey palette entry against
// the best entry so far and hands the updated item to the next cell.
// Depends on rtxq_pkg.
module rtxq_grey_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [rtxq_pkg::ChanW-1:0]       grey_i,
  input  logic [rtxq_pkg::IndexW-1:0]      grey_index_i,
  input  logic                             valid_i,
  input  rtxq_pkg::item_t                  item_i,
  output logic                             valid_o,
  output rtxq_pkg::item_t                  item_o
);

  logic                        valid_q;
  rtxq_pkg::item_t             item_q;
  rtxq_pkg::item_t             item_d;
  logic [rtxq_pkg::ChanW-1:0]  rd, gd, bd;
  logic [2*rtxq_pkg::ChanW-1:0] rsq, gsq, bsq;
  logic [rtxq_pkg::ErrW-1:0]   err;

  always_comb begin
    rd  = rtxq_pkg::abs_diff(item_i.red,   grey_i);
    gd  = rtxq_pkg::abs_diff(item_i.green, grey_i);
    bd  = rtxq_pkg::abs_diff(item_i.blue,  grey_i);
    rsq = (2*rtxq_pkg::ChanW)'(rd) * (2*rtxq_pkg::ChanW)'(rd);
    gsq = (2*rtxq_pkg::ChanW)'(gd) * (2*rtxq_pkg::ChanW)'(gd);
    bsq = (2*rtxq_pkg::ChanW)'(bd) * (2*rtxq_pkg::ChanW)'(bd);
    err = rtxq_pkg::ErrW'(rsq) + rtxq_pkg::ErrW'(gsq) + rtxq_pkg::ErrW'(bsq);
    item_d = item_i;
    // Only a strictly smaller distance replaces the best so far.
    if (err < item_i.best_err) begin
      item_d.best_err   = err;
      item_d.best_index = grey_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- design/rgb_to_xterm256_quantizer.sv -----
// Top level of the xterm-256 quantizer: a cube cell followed by a chain of
// 24 grey cells. Depends on rtxq_pkg, rtxq_cube_cell and rtxq_grey_cell.
//
// Usage:
//   A request is a 24-bit pixel on red_i, green_i and blue_i, taken at a rising
//   clock edge where start_i is high and busy_o is low. busy_o is always low:
//   every stage of the chain moves forward on every cycle, so a new request can
//   be taken on every clock.
//   The result, palette_index_o, appears on the result port for exactly one
//   cycle, marked by done_o. Results leave in request order.
//   A pixel passes the level-snap stage and then the squared-error and
//   cube-index stage of the cube cell, then the stage of each of the 24 grey
//   cells. Throughput is one pixel per clock, set by the one-stage-per-cell
//   chain.
//   Each grey cell compares its own grey entry against the best entry carried
//   along with the pixel, and replaces it only on a strictly smaller squared
//   distance, so the cube entry and earlier grey entries win ties.
//   Reset clears only the valid bits of the chain; no result is produced for
//   data that was in flight. The receiver cannot stall the block, and none of
//   its results are held back.
module rgb_to_xterm256_quantizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [rtxq_pkg::ChanW-1:0]    red_i,
  input  logic [rtxq_pkg::ChanW-1:0]    green_i,
  input  logic [rtxq_pkg::ChanW-1:0]    blue_i,
  output logic                          done_o,
  output logic [rtxq_pkg::IndexW-1:0]   palette_index_o
);

  // Chain links: link 0 leaves the cube cell, link k+1 leaves grey cell k.
  logic            link_valid [rtxq_pkg::GreyCount+1];
  rtxq_pkg::item_t link_item  [rtxq_pkg::GreyCount+1];
  logic            accept;

  // The chain never stalls, so the block is never busy.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  rtxq_cube_cell u_cube_cell (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (link_valid[0]),
    .item_o  (link_item[0])
  );

  // Grey entry k has value 8 + 10*k on every channel and palette index 232 + k.
  for (genvar k = 0; k < rtxq_pkg::GreyCount; k++) begin : g_grey
    localparam logic [rtxq_pkg::ChanW-1:0] GreyValue =
      rtxq_pkg::ChanW'(rtxq_pkg::GreyOffset + rtxq_pkg::GreyStep * k);
    localparam logic [rtxq_pkg::IndexW-1:0] GreyIndex =
      rtxq_pkg::IndexW'(rtxq_pkg::GreyFirst + k);

    rtxq_grey_cell u_grey_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .grey_i       (GreyValue),
      .grey_index_i (GreyIndex),
      .valid_i      (link_valid[k]),
      .item_i       (link_item[k]),
      .valid_o      (link_valid[k+1]),
      .item_o       (link_item[k+1])
    );
  end

  // The last cell's register is the result register.
  assign done_o          = link_valid[rtxq_pkg::GreyCount];
  assign palette_index_o = link_item[rtxq_pkg::GreyCount].best_index;

endmodule
